@@ design/cpfp_pkg.sv @@
// Package for the cell port frame poller: word types, command and cause codes,
// protocol characters, register reset values and controller/datapath structs.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package cpfp_pkg;

    // Input word: one event for the poller.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } t_in_word;

    // Output word: one port record.
    typedef struct packed {
        logic [4:0] port;
        logic [7:0] low_byte;
        logic [7:0] high_byte;
        logic       balancing;
        logic [1:0] cause;
        logic       scan_wrapped;
        logic       last;
    } t_out_word;

    // Event codes.
    localparam logic [1:0] CMD_RX_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_OVERRUN = 2'd2;

    // Record causes.
    localparam logic [1:0] CAUSE_FRAME   = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_NO_CONN = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECTED_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 1'd1;
    localparam int unsigned CFG_DATA_W = 32;

    // Frame characters.
    localparam logic [7:0] CH_START = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BAL   = 8'h4F;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] NO_FRAME = 8'hFF;
    localparam logic [7:0] TICK_MAX = 8'hFF;

    // Register reset values.
    localparam logic [31:0] MASK_RESET    = 32'h9999_9999;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_word;   // input word accepted this cycle
        logic scan_emit;   // emit one scan record this cycle
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;   // output register can load this cycle
        logic scan_hit;    // current port needs a timeout or no-connect record
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/cpfp_ctrl.sv @@
// Controller for the cell port frame poller: accepts a word, then scans ports
// one record per cycle unless stalled. Uses cpfp_pkg command/status structs.
`default_nettype none

module cpfp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  cpfp_pkg::t_dp_stat    i_stat,
    output cpfp_pkg::t_dp_cmd     o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    // Ready only while idle and the output register can take a frame record.
    assign o_in_ready = (r_state == ST_IDLE) && i_stat.slot_free;

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd.take_word = 1'b0;
        o_cmd.scan_emit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_stat.slot_free) begin
                    o_cmd.take_word = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.slot_free) begin
                    if (i_stat.scan_hit) begin
                        o_cmd.scan_emit = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/cpfp_dp.sv @@
// Datapath for the cell port frame poller: frame buffer, counters, config
// registers and the output word register. Uses cpfp_pkg types and constants.
`default_nettype none

module cpfp_dp #(
    parameter int unsigned NUM_PORTS = 32,
    parameter int unsigned BUF_LEN   = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  cpfp_pkg::t_dp_cmd                      i_cmd,
    output cpfp_pkg::t_dp_stat                     o_stat,
    input  cpfp_pkg::t_in_word                     i_in_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [cpfp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cpfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output cpfp_pkg::t_out_word                    o_out_data
);

    localparam int unsigned BCW = $clog2(BUF_LEN + 1);
    localparam int unsigned BIW = $clog2(BUF_LEN);
    localparam int unsigned NW  = $clog2(NUM_PORTS + 1);

    logic [31:0]    r_mask;
    logic [7:0]     r_timeout;
    logic [4:0]     r_port,  n_port;
    logic [BCW-1:0] r_bc,    n_bc;
    logic [7:0]     r_tick,  n_tick;
    logic [NW-1:0]  r_cnt,   n_cnt;
    logic [7:0]     r_buf [BUF_LEN];
    logic [7:0]     n_buf [BUF_LEN];
    logic           r_out_valid, n_out_valid;
    cpfp_pkg::t_out_word r_out, n_out;

    logic           slot_free;
    logic [BCW-1:0] bc_prev;
    logic [5:0]     port_inc;
    logic [4:0]     next_port;
    logic           wrap;
    logic           timed_out;
    logic           frame_done;
    logic           more_after;

    assign slot_free = !r_out_valid || i_out_ready;

    // Port advance with wrap at the last port.
    assign port_inc  = {1'b0, r_port} + 6'd1;
    assign wrap      = (port_inc >= 6'(NUM_PORTS));
    assign next_port = wrap ? 5'd0 : port_inc[4:0];

    assign timed_out = (r_tick > r_timeout);
    assign bc_prev   = r_bc - BCW'(1);

    // A NUL after a stored CR completes the frame when slot 2 holds a dash.
    assign frame_done = (i_in_data.cmd == cpfp_pkg::CMD_RX_BYTE)
                     && (i_in_data.rx_byte != cpfp_pkg::CH_START)
                     && (r_bc != '0)
                     && (i_in_data.rx_byte == cpfp_pkg::CH_NUL)
                     && (r_buf[bc_prev[BIW-1:0]] == cpfp_pkg::CH_CR)
                     && (r_buf[2] == cpfp_pkg::CH_DASH);

    // After any record the tick count is zero, so another record follows only
    // when the next port is unconnected and the record cap is not reached.
    always_comb begin
        logic [NW-1:0] cnt_base;
        cnt_base   = i_cmd.take_word ? '0 : r_cnt;
        more_after = ((cnt_base + NW'(1)) < NW'(NUM_PORTS)) && !r_mask[next_port];
    end

    assign o_stat.slot_free = slot_free;
    assign o_stat.scan_hit  = (r_cnt < NW'(NUM_PORTS)) && (timed_out || !r_mask[r_port]);

    // Next state of the poller.
    always_comb begin
        n_port      = r_port;
        n_bc        = r_bc;
        n_tick      = r_tick;
        n_cnt       = r_cnt;
        n_buf       = r_buf;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.take_word) begin
            n_cnt = '0;
            case (i_in_data.cmd)
                cpfp_pkg::CMD_OVERRUN: begin
                    n_bc = '0;
                end
                cpfp_pkg::CMD_TICK: begin
                    if (r_tick != cpfp_pkg::TICK_MAX) begin
                        n_tick = r_tick + 8'd1;
                    end
                end
                cpfp_pkg::CMD_RX_BYTE: begin
                    n_tick = '0;
                    if (i_in_data.rx_byte == cpfp_pkg::CH_START) begin
                        n_buf[0] = cpfp_pkg::CH_ZERO;
                        n_bc     = BCW'(1);
                    end else if (frame_done) begin
                        n_out.port         = r_port;
                        n_out.low_byte     = r_buf[3];
                        n_out.high_byte    = r_buf[4];
                        n_out.balancing    = (r_buf[1] == cpfp_pkg::CH_BAL);
                        n_out.cause        = cpfp_pkg::CAUSE_FRAME;
                        n_out.scan_wrapped = wrap;
                        n_out.last         = !more_after;
                        n_out_valid        = 1'b1;
                        n_cnt              = NW'(1);
                        n_port             = next_port;
                        n_bc               = '0;
                        for (int i = 0; i < BUF_LEN; i++) begin
                            n_buf[i] = '0;
                        end
                    end else if (r_bc != '0 && r_bc < BCW'(BUF_LEN)) begin
                        n_buf[r_bc[BIW-1:0]] = i_in_data.rx_byte;
                        n_bc                 = r_bc + BCW'(1);
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.scan_emit) begin
            n_out.port         = r_port;
            n_out.low_byte     = cpfp_pkg::NO_FRAME;
            n_out.high_byte    = cpfp_pkg::NO_FRAME;
            n_out.balancing    = 1'b0;
            n_out.cause        = timed_out ? cpfp_pkg::CAUSE_TIMEOUT
                                           : cpfp_pkg::CAUSE_NO_CONN;
            n_out.scan_wrapped = wrap;
            n_out.last         = !more_after;
            n_out_valid        = 1'b1;
            n_cnt              = r_cnt + NW'(1);
            n_port             = next_port;
            n_bc               = '0;
            n_tick             = '0;
        end
    end

    // Control and buffer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= cpfp_pkg::MASK_RESET;
            r_timeout   <= cpfp_pkg::TIMEOUT_RESET;
            r_port      <= '0;
            r_bc        <= '0;
            r_tick      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BUF_LEN; i++) begin
                r_buf[i] <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_idx == cpfp_pkg::REG_CONNECTED_MASK) begin
                r_mask <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == cpfp_pkg::REG_TIMEOUT_TICKS) begin
                r_timeout <= i_cfg_data[7:0];
            end
            r_port      <= n_port;
            r_bc        <= n_bc;
            r_tick      <= n_tick;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_buf       <= n_buf;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ design/cell_port_frame_poller_unit.sv @@
// Top level of the cell port frame poller: controller plus datapath.
// Depends on cpfp_pkg, cpfp_ctrl and cpfp_dp.
//
//   channel   signals                              direction  word type
//   in        i_in_valid / o_in_ready / i_in_data  input      t_in_word
//   out       o_out_valid / i_out_ready / o_out_data output   t_out_word
//   config    i_cfg_we / i_cfg_idx / i_cfg_data    input      write only
//
// A word is taken in an accept step, which loads a frame record if the word
// completes a frame; then the port scan emits one record per cycle while the
// output can load, and ends with a closing scan step. Synchronous active-low
// reset clears port, counters, buffer and output valid and presets registers.
// A stalled output holds the scan; no new word is taken until the scan ends.
`default_nettype none

module cell_port_frame_poller_unit #(
    parameter int unsigned NUM_PORTS = 32,
    parameter int unsigned BUF_LEN   = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  cpfp_pkg::t_in_word                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output cpfp_pkg::t_out_word                    o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [cpfp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cpfp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    cpfp_pkg::t_dp_cmd  dp_cmd;
    cpfp_pkg::t_dp_stat dp_stat;

    // Sequencer for accept and scan steps.
    cpfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Frame buffer, scan state and output register.
    cpfp_dp #(
        .NUM_PORTS (NUM_PORTS),
        .BUF_LEN   (BUF_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
